// ===== hdl/bfha_pkg.sv =====
// ----------------------------------------------------------------------------
// bfha_pkg
// Shared widths and codes of the best-fit heap allocator.
// ----------------------------------------------------------------------------
package bfha_pkg;

    localparam int CMD_W    = 2;
    localparam int SIZE_W   = 16;
    localparam int UADDR_W  = 16;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 32;
    localparam int LIMIT_W  = 17;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESIZE  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OOM     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

endpackage

// ===== hdl/bfha_req_if.sv =====
// ----------------------------------------------------------------------------
// bfha_req_if
// Request channel: command, size and user address with valid/ready.
// ----------------------------------------------------------------------------
interface bfha_req_if;
    import bfha_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [SIZE_W-1:0]    req_size;
    logic [UADDR_W-1:0]   user_addr;

    modport source (output valid, command, req_size, user_addr, input ready);
    modport sink   (input valid, command, req_size, user_addr, output ready);
endinterface

// ===== hdl/bfha_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bfha_rsp_if
// Result channel: address, status, copy length and counters with valid/ready.
// ----------------------------------------------------------------------------
interface bfha_rsp_if;
    import bfha_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [UADDR_W-1:0]   result_addr;
    logic [STATUS_W-1:0]  status;
    logic [SIZE_W-1:0]    copy_bytes;
    logic [CNT_W-1:0]     usage_now;
    logic [CNT_W-1:0]     alloc_total;
    logic [CNT_W-1:0]     freed_total;
    logic [CNT_W-1:0]     alloc_events;

    modport source (output valid, result_addr, status, copy_bytes, usage_now,
                    alloc_total, freed_total, alloc_events, input ready);
    modport sink   (input valid, result_addr, status, copy_bytes, usage_now,
                    alloc_total, freed_total, alloc_events, output ready);
endinterface

// ===== hdl/best_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// best_fit_heap_allocator
// Best-fit heap allocator with coalescing of free neighbors.
// ----------------------------------------------------------------------------
// The block table sits in a single-port-read memory and is walked by one
// compare unit, one entry at a time in a read state and then an evaluate
// state. A request takes a lookup walk, a best-fit walk, or both, plus merge
// bookkeeping and, when entries are removed, a compaction walk over the
// tail of the table.
// Ready is high only while idle; a finished result waits in an output
// register, so the next request may be taken before it is collected.
module best_fit_heap_allocator #(
    parameter int HEAP_BYTES   = 65536,
    parameter int MAX_ENTRIES  = 64,
    parameter int HEADER_BYTES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bfha_pkg::LIMIT_W-1:0] cfg_wdata,
    bfha_req_if.sink                  req,
    bfha_rsp_if.source                rsp
);
    import bfha_pkg::*;

    localparam int AW = $clog2(HEAP_BYTES + 1);
    localparam int SW = (AW > SIZE_W) ? AW : SIZE_W;
    localparam int XW = SW + 2;
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = 2 * AW + 1;

    localparam logic [XW-1:0] HDR_X  = XW'(HEADER_BYTES);
    localparam logic [AW-1:0] HDR_A  = AW'(HEADER_BYTES);
    localparam logic [XW-1:0] HEAP_X = XW'(HEAP_BYTES);
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE, S_FIND_RD, S_FIND_EV, S_FIT_RD, S_FIT_EV, S_FIT_END,
        S_REL_CHK, S_PREV_RD, S_PREV_EV, S_NEXT_RD, S_NEXT_EV, S_MERGE,
        S_SHIFT_RD, S_SHIFT_EV, S_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [SIZE_W-1:0]      size_reg, size_next;
    logic [UADDR_W-1:0]     addr_reg, addr_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          j_reg, j_next;
    logic [AW-1:0]          j_off_reg, j_off_next;
    logic [AW-1:0]          j_size_reg, j_size_next;
    logic                   resize_reg, resize_next;
    logic                   found_reg, found_next;
    logic [IW-1:0]          best_reg, best_next;
    logic [AW-1:0]          best_off_reg, best_off_next;
    logic [AW-1:0]          best_size_reg, best_size_next;
    logic                   p_free_reg, p_free_next;
    logic [AW-1:0]          p_off_reg, p_off_next;
    logic [AW-1:0]          p_size_reg, p_size_next;
    logic                   n_free_reg, n_free_next;
    logic [AW-1:0]          n_size_reg, n_size_next;
    logic [1:0]             dist_reg, dist_next;
    logic [UADDR_W-1:0]     res_reg, res_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [SIZE_W-1:0]      copy_reg, copy_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [AW-1:0]          top_reg, top_next;
    logic [CNT_W-1:0]       usage_reg, usage_next;
    logic [CNT_W-1:0]       grown_reg, grown_next;
    logic [CNT_W-1:0]       freed_reg, freed_next;
    logic [CNT_W-1:0]       events_reg, events_next;
    logic [LIMIT_W-1:0]     limit_reg;
    logic                   rsp_valid_reg;
    logic                   rsp_load;

    logic                   mem_rd_en, mem_wr_en;
    logic [IW-1:0]          mem_rd_addr, mem_wr_addr;
    logic [EW-1:0]          mem_rd_data, mem_wr_data;

    logic [AW-1:0]          rd_off, rd_size;
    logic                   rd_free;
    logic [XW-1:0]          size_x, limit_x;
    logic [CW-1:0]          jm1, jp1;
    logic [CW:0]            src_x;

    assign rd_off  = mem_rd_data[AW-1:0];
    assign rd_size = mem_rd_data[2*AW-1:AW];
    assign rd_free = mem_rd_data[2*AW];
    assign size_x  = XW'(size_reg);
    assign limit_x = (XW'(limit_reg) < HEAP_X) ? XW'(limit_reg) : HEAP_X;
    assign jm1     = j_reg - CW'(1);
    assign jp1     = j_reg + CW'(1);
    assign src_x   = (CW+1)'(idx_reg) + (CW+1)'(dist_reg);

    bfha_table #(.DATA_W(EW), .DEPTH(MAX_ENTRIES)) u_table (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        size_next      = size_reg;
        addr_next      = addr_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        j_off_next     = j_off_reg;
        j_size_next    = j_size_reg;
        resize_next    = resize_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_off_next  = best_off_reg;
        best_size_next = best_size_reg;
        p_free_next    = p_free_reg;
        p_off_next     = p_off_reg;
        p_size_next    = p_size_reg;
        n_free_next    = n_free_reg;
        n_size_next    = n_size_reg;
        dist_next      = dist_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        copy_next      = copy_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        usage_next     = usage_reg;
        grown_next     = grown_reg;
        freed_next     = freed_reg;
        events_next    = events_reg;
        rsp_load       = 1'b0;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = idx_reg[IW-1:0];
        mem_wr_en      = 1'b0;
        mem_wr_addr    = idx_reg[IW-1:0];
        mem_wr_data    = mem_rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next    = req.command;
                    size_next   = req.req_size;
                    addr_next   = req.user_addr;
                    res_next    = '0;
                    copy_next   = '0;
                    status_next = STATUS_OK;
                    resize_next = 1'b0;
                    found_next  = 1'b0;
                    idx_next    = '0;
                    if (req.command == CMD_ALLOC ||
                        (req.command == CMD_RESIZE && req.user_addr == '0))
                    begin
                        if (req.req_size == '0)
                        begin
                            status_next = STATUS_NULL;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_FIT_RD;
                        end
                    end
                    else if (req.command == CMD_RELEASE || req.command == CMD_RESIZE)
                    begin
                        if (req.user_addr == '0)
                        begin
                            status_next = STATUS_NULL;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_FIND_RD;
                        end
                    end
                    else
                    begin
                        status_next = STATUS_NULL;
                        state_next  = S_FINISH;
                    end
                end
            end

            S_FIND_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    status_next = STATUS_UNKNOWN;
                    state_next  = S_FINISH;
                end
                else
                begin
                    mem_rd_en  = 1'b1;
                    state_next = S_FIND_EV;
                end
            end

            S_FIND_EV:
            begin
                if (XW'(rd_off) + HDR_X == XW'(addr_reg))
                begin
                    j_next      = idx_reg;
                    j_off_next  = rd_off;
                    j_size_next = rd_size;
                    if (cmd_reg == CMD_RELEASE || size_reg == '0)
                    begin
                        state_next = S_REL_CHK;
                    end
                    else if (XW'(rd_size) >= size_x)
                    begin
                        res_next   = addr_reg;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        resize_next = 1'b1;
                        found_next  = 1'b0;
                        idx_next    = '0;
                        state_next  = S_FIT_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_FIND_RD;
                end
            end

            S_FIT_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    state_next = S_FIT_END;
                end
                else
                begin
                    mem_rd_en  = 1'b1;
                    state_next = S_FIT_EV;
                end
            end

            S_FIT_EV:
            begin
                if (rd_free && XW'(rd_size) >= size_x &&
                    (!found_reg || rd_size < best_size_reg))
                begin
                    found_next     = 1'b1;
                    best_next      = idx_reg[IW-1:0];
                    best_off_next  = rd_off;
                    best_size_next = rd_size;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = S_FIT_RD;
            end

            S_FIT_END:
            begin
                if (found_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = best_reg;
                    mem_wr_data = {1'b0, best_size_reg, best_off_reg};
                    usage_next  = usage_reg + CNT_W'(size_reg);
                    events_next = events_reg + CNT_W'(1);
                    res_next    = UADDR_W'(XW'(best_off_reg) + HDR_X);
                    copy_next   = resize_reg ? SIZE_W'(j_size_reg) : '0;
                    state_next  = resize_reg ? S_REL_CHK : S_FINISH;
                end
                else if (count_reg >= MAX_C ||
                         XW'(top_reg) + HDR_X + size_x > limit_x)
                begin
                    status_next = STATUS_OOM;
                    state_next  = S_FINISH;
                end
                else
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = count_reg[IW-1:0];
                    mem_wr_data = {1'b0, AW'(size_reg), top_reg};
                    count_next  = count_reg + CW'(1);
                    top_next    = AW'(XW'(top_reg) + HDR_X + size_x);
                    grown_next  = grown_reg + CNT_W'(size_reg);
                    usage_next  = usage_reg + CNT_W'(size_reg);
                    events_next = events_reg + CNT_W'(1);
                    res_next    = UADDR_W'(XW'(top_reg) + HDR_X);
                    copy_next   = resize_reg ? SIZE_W'(j_size_reg) : '0;
                    state_next  = resize_reg ? S_REL_CHK : S_FINISH;
                end
            end

            S_REL_CHK:
            begin
                p_free_next = 1'b0;
                n_free_next = 1'b0;
                if (XW'(j_off_reg) + HDR_X + XW'(j_size_reg) == XW'(top_reg))
                begin
                    top_next   = j_off_reg;
                    count_next = count_reg - CW'(1);
                    freed_next = freed_reg + CNT_W'(j_size_reg);
                    usage_next = usage_reg - CNT_W'(j_size_reg);
                    state_next = S_FINISH;
                end
                else if (j_reg != '0)
                begin
                    state_next = S_PREV_RD;
                end
                else if (jp1 < count_reg)
                begin
                    state_next = S_NEXT_RD;
                end
                else
                begin
                    state_next = S_MERGE;
                end
            end

            S_PREV_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = jm1[IW-1:0];
                state_next  = S_PREV_EV;
            end

            S_PREV_EV:
            begin
                p_free_next = rd_free;
                p_off_next  = rd_off;
                p_size_next = rd_size;
                state_next  = (jp1 < count_reg) ? S_NEXT_RD : S_MERGE;
            end

            S_NEXT_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = jp1[IW-1:0];
                state_next  = S_NEXT_EV;
            end

            S_NEXT_EV:
            begin
                n_free_next = rd_free;
                n_size_next = rd_size;
                state_next  = S_MERGE;
            end

            S_MERGE:
            begin
                mem_wr_en  = 1'b1;
                dist_next  = 2'd1;
                idx_next   = j_reg;
                state_next = S_SHIFT_RD;
                freed_next = freed_reg + CNT_W'(j_size_reg);
                usage_next = usage_reg - CNT_W'(j_size_reg);
                if (p_free_reg && n_free_reg)
                begin
                    mem_wr_addr = jm1[IW-1:0];
                    mem_wr_data = {1'b1, p_size_reg + HDR_A + j_size_reg + HDR_A + n_size_reg,
                                   p_off_reg};
                    dist_next   = 2'd2;
                end
                else if (p_free_reg)
                begin
                    mem_wr_addr = jm1[IW-1:0];
                    mem_wr_data = {1'b1, p_size_reg + HDR_A + j_size_reg, p_off_reg};
                end
                else if (n_free_reg)
                begin
                    mem_wr_addr = j_reg[IW-1:0];
                    mem_wr_data = {1'b1, j_size_reg + HDR_A + n_size_reg, j_off_reg};
                    idx_next    = jp1;
                    freed_next  = freed_reg + CNT_W'(j_size_reg + HDR_A + n_size_reg);
                    usage_next  = usage_reg - CNT_W'(j_size_reg + HDR_A + n_size_reg);
                end
                else
                begin
                    mem_wr_addr = j_reg[IW-1:0];
                    mem_wr_data = {1'b1, j_size_reg, j_off_reg};
                    state_next  = S_FINISH;
                end
            end

            // compaction: entry src moves down to idx
            S_SHIFT_RD:
            begin
                if (src_x >= (CW+1)'(count_reg))
                begin
                    count_next = count_reg - CW'(dist_reg);
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = src_x[IW-1:0];
                    state_next  = S_SHIFT_EV;
                end
            end

            S_SHIFT_EV:
            begin
                mem_wr_en  = 1'b1;
                idx_next   = idx_reg + CW'(1);
                state_next = S_SHIFT_RD;
            end

            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            top_reg       <= '0;
            usage_reg     <= '0;
            grown_reg     <= '0;
            freed_reg     <= '0;
            events_reg    <= '0;
            limit_reg     <= LIMIT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            top_reg    <= top_next;
            usage_reg  <= usage_next;
            grown_reg  <= grown_next;
            freed_reg  <= freed_next;
            events_reg <= events_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        size_reg      <= size_next;
        addr_reg      <= addr_next;
        idx_reg       <= idx_next;
        j_reg         <= j_next;
        j_off_reg     <= j_off_next;
        j_size_reg    <= j_size_next;
        resize_reg    <= resize_next;
        found_reg     <= found_next;
        best_reg      <= best_next;
        best_off_reg  <= best_off_next;
        best_size_reg <= best_size_next;
        p_free_reg    <= p_free_next;
        p_off_reg     <= p_off_next;
        p_size_reg    <= p_size_next;
        n_free_reg    <= n_free_next;
        n_size_reg    <= n_size_next;
        dist_reg      <= dist_next;
        res_reg       <= res_next;
        status_reg    <= status_next;
        copy_reg      <= copy_next;
        if (rsp_load)
        begin
            rsp.result_addr  <= res_reg;
            rsp.status       <= status_reg;
            rsp.copy_bytes   <= copy_reg;
            rsp.usage_now    <= usage_reg;
            rsp.alloc_total  <= grown_reg;
            rsp.freed_total  <= freed_reg;
            rsp.alloc_events <= events_reg;
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
endmodule

// ===== hdl/bfha_table.sv =====
// ----------------------------------------------------------------------------
// bfha_table
// Block table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfha_table #(
    parameter int DATA_W = 35,
    parameter int DEPTH  = 64
) (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [DATA_W-1:0]         rd_data,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic [DATA_W-1:0]         wr_data
);
    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== hdl/bfha_checker.sv =====
// ----------------------------------------------------------------------------
// bfha_checker
// Port-level checks on the best-fit heap allocator.
// ----------------------------------------------------------------------------
module bfha_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [bfha_pkg::UADDR_W-1:0]    result_addr,
    input logic [bfha_pkg::STATUS_W-1:0]   status,
    input logic [bfha_pkg::SIZE_W-1:0]     copy_bytes
);
    import bfha_pkg::*;

    // one request in flight
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready high right after a request was taken");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_addr) && $stable(status))
        else $error("stalled result changed");

    a_fail_null_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != STATUS_OK |-> result_addr == '0 && copy_bytes == '0)
        else $error("failed request returned an address or copy length");

    a_copy_on_move: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && copy_bytes != '0 |-> result_addr != '0)
        else $error("copy length without a new address");
endmodule

bind best_fit_heap_allocator bfha_checker u_bfha_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .result_addr (rsp.result_addr),
    .status      (rsp.status),
    .copy_bytes  (rsp.copy_bytes)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the best-fit heap allocator: a queue-fed request
// driver, a result monitor and a predictor of the block table and counters.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bfha_pkg::*;

    localparam int HDR     = 16;
    localparam int ENTRIES = 64;
    localparam int HEAP    = 65536;

    localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [SIZE_W-1:0]  req_size;
        logic [UADDR_W-1:0] user_addr;
    } request_t;

    typedef struct packed {
        logic [UADDR_W-1:0]  result_addr;
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   copy_bytes;
        logic [CNT_W-1:0]    usage_now;
        logic [CNT_W-1:0]    alloc_total;
        logic [CNT_W-1:0]    freed_total;
        logic [CNT_W-1:0]    alloc_events;
    } result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;

    bfha_req_if req ();
    bfha_rsp_if rsp ();

    best_fit_heap_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    // predictor state
    int unsigned blk_off  [ENTRIES];
    int unsigned blk_size [ENTRIES];
    bit          blk_free [ENTRIES];
    int unsigned blk_count;
    int unsigned top_ptr;
    bit [31:0]   used_cnt, grown_cnt, freed_cnt, ok_cnt;
    int unsigned limit_reg;

    request_t pending_reqs[$];
    result_t  expected_rsps[$];
    int errors = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int find_blk(int unsigned a);
        for (int i = 0; i < blk_count; i++)
            if (blk_off[i] + HDR == a)
                return i;
        return -1;
    endfunction

    function automatic int unsigned heap_alloc(int unsigned sz);
        int best;
        int unsigned lim;
        best = -1;
        lim = (limit_reg < HEAP) ? limit_reg : HEAP;
        for (int i = 0; i < blk_count; i++)
            if (blk_free[i] && blk_size[i] >= sz && (best < 0 || blk_size[i] < blk_size[best]))
                best = i;
        if (best >= 0)
        begin
            blk_free[best] = 0;
            used_cnt += sz;
            ok_cnt++;
            return blk_off[best] + HDR;
        end
        if (blk_count >= ENTRIES || top_ptr + HDR + sz > lim)
            return 0;
        blk_off[blk_count] = top_ptr;
        blk_size[blk_count] = sz;
        blk_free[blk_count] = 0;
        blk_count++;
        top_ptr += HDR + sz;
        grown_cnt += sz;
        used_cnt += sz;
        ok_cnt++;
        return top_ptr - sz;
    endfunction

    function automatic void heap_release(int unsigned j);
        int unsigned amount, k;
        bit absorbed;
        amount = blk_size[j];
        k = 0;
        absorbed = 0;
        if (blk_off[j] + HDR + blk_size[j] == top_ptr)
        begin
            top_ptr -= HDR + blk_size[j];
            blk_count--;
        end
        else
        begin
            blk_free[j] = 1;
            while (k + 1 < blk_count)
            begin
                if (blk_free[k] && blk_free[k+1])
                begin
                    blk_size[k] += HDR + blk_size[k+1];
                    if (!absorbed)
                    begin
                        if (k + 1 == j)
                            absorbed = 1;
                        else if (k + 1 < j)
                            j--;
                    end
                    for (int m = k + 1; m + 1 < blk_count; m++)
                    begin
                        blk_off[m] = blk_off[m+1];
                        blk_size[m] = blk_size[m+1];
                        blk_free[m] = blk_free[m+1];
                    end
                    blk_count--;
                end
                else
                    k++;
            end
            if (!absorbed)
                amount = blk_size[j];
        end
        freed_cnt += amount;
        used_cnt -= amount;
    endfunction

    function automatic result_t predict_heap_op(request_t r);
        result_t o;
        int idx;
        int unsigned sz, a;
        o = '0;
        sz = 32'(r.req_size);
        a = 32'(r.user_addr);
        if (r.command == CMD_ALLOC || (r.command == CMD_RESIZE && a == 0))
        begin
            if (sz == 0)
                o.status = STATUS_NULL;
            else
            begin
                o.result_addr = UADDR_W'(heap_alloc(sz));
                if (o.result_addr == 0)
                    o.status = STATUS_OOM;
            end
        end
        else if (r.command == CMD_RELEASE || r.command == CMD_RESIZE)
        begin
            if (a == 0)
                o.status = STATUS_NULL;
            else
            begin
                idx = find_blk(a);
                if (idx < 0)
                    o.status = STATUS_UNKNOWN;
                else if (r.command == CMD_RELEASE || sz == 0)
                    heap_release(idx);
                else if (blk_size[idx] >= sz)
                    o.result_addr = r.user_addr;
                else
                begin
                    o.result_addr = UADDR_W'(heap_alloc(sz));
                    if (o.result_addr == 0)
                        o.status = STATUS_OOM;
                    else
                    begin
                        o.copy_bytes = SIZE_W'(blk_size[idx]);
                        heap_release(idx);
                    end
                end
            end
        end
        else
            o.status = STATUS_NULL;
        o.usage_now = used_cnt;
        o.alloc_total = grown_cnt;
        o.freed_total = freed_cnt;
        o.alloc_events = ok_cnt;
        return o;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 40)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    int unsigned accepted;

    // driver
    int unsigned drv_gap;
    int unsigned sent;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            drv_gap = 0;
        end
        else if (req.valid && sent != accepted)
        begin
            // hold until taken
        end
        else if (drv_gap > 0)
        begin
            drv_gap--;
            req.valid <= 1'b0;
        end
        else if (pending_reqs.size() > 0)
        begin
            req.valid <= 1'b1;
            req.command <= pending_reqs[0].command;
            req.req_size <= pending_reqs[0].req_size;
            req.user_addr <= pending_reqs[0].user_addr;
            sent++;
            drv_gap = gap_len();
        end
        else
            req.valid <= 1'b0;
    end

    // request accept: pop and predict at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
        begin
            expected_rsps.push_back(predict_heap_op(pending_reqs.pop_front()));
            accepted++;
        end
    end

    int unsigned mon_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (mon_gap > 0)
        begin
            mon_gap--;
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= 1'b1;
            mon_gap = gap_len();
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_t got, exp_r;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = '{rsp.result_addr, rsp.status, rsp.copy_bytes, rsp.usage_now,
                    rsp.alloc_total, rsp.freed_total, rsp.alloc_events};
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: result with none expected: %h", $realtime, got);
                errors++;
            end
            else
            begin
                exp_r = expected_rsps.pop_front();
                if (got.result_addr != exp_r.result_addr)
                    $display("%0t: result_addr exp %h got %h", $realtime,
                             exp_r.result_addr, got.result_addr);
                if (got.status != exp_r.status)
                    $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, got.status);
                if (got.copy_bytes != exp_r.copy_bytes)
                    $display("%0t: copy_bytes exp %0d got %0d", $realtime,
                             exp_r.copy_bytes, got.copy_bytes);
                if (got.usage_now != exp_r.usage_now)
                    $display("%0t: usage_now exp %0d got %0d", $realtime,
                             exp_r.usage_now, got.usage_now);
                if (got.alloc_total != exp_r.alloc_total)
                    $display("%0t: alloc_total exp %0d got %0d", $realtime,
                             exp_r.alloc_total, got.alloc_total);
                if (got.freed_total != exp_r.freed_total)
                    $display("%0t: freed_total exp %0d got %0d", $realtime,
                             exp_r.freed_total, got.freed_total);
                if (got.alloc_events != exp_r.alloc_events)
                    $display("%0t: alloc_events exp %0d got %0d", $realtime,
                             exp_r.alloc_events, got.alloc_events);
                if (got != exp_r)
                    errors++;
            end
        end
    end

    // addresses are chosen from a shadow of block starts built at queue time
    int unsigned shadow_top;
    int unsigned shadow_addrs[$];

    function automatic logic [UADDR_W-1:0] pick_addr();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 75 && shadow_addrs.size() > 0)
            return UADDR_W'(shadow_addrs[$urandom_range(0, shadow_addrs.size() - 1)]);
        if (p < 85)
            return 16'd0;
        return UADDR_W'($urandom());
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return SIZE_W'($urandom_range(1, 64));
        if (p < 90)
            return SIZE_W'($urandom_range(65, 1024));
        if (p < 95)
            return 16'd0;
        return SIZE_W'($urandom());
    endfunction

    task automatic queue_req(logic [CMD_W-1:0] c, logic [SIZE_W-1:0] s,
                             logic [UADDR_W-1:0] a);
        request_t r;
        r.command = c;
        r.req_size = s;
        r.user_addr = a;
        pending_reqs.push_back(r);
        if ((c == CMD_ALLOC || c == CMD_RESIZE) && s != 0)
        begin
            shadow_addrs.push_back(shadow_top + HDR);
            shadow_top += HDR + 32'(s);
            if (shadow_top > 60000 || shadow_addrs.size() > 128)
            begin
                shadow_top = 0;
                shadow_addrs.delete();
            end
        end
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
        repeat (450) @(posedge clk);
    endtask

    task automatic write_limit(int unsigned v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v[LIMIT_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        limit_reg = v;
    endtask

    initial
    begin
        int unsigned lims[4];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        limit_reg = 32'(LIMIT_RESET);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        write_limit(17'h1FFFF);
        queue_req(CMD_ALLOC, 16'd0, 16'd0);
        queue_req(CMD_RELEASE, 16'd0, 16'd0);
        queue_req(CMD_BAD, 16'hFFFF, 16'hFFFF);
        queue_req(CMD_ALLOC, 16'd32, 16'd0);
        queue_req(CMD_ALLOC, 16'd64, 16'd0);
        queue_req(CMD_ALLOC, 16'd32, 16'd0);
        queue_req(CMD_ALLOC, 16'd8, 16'd0);
        queue_req(CMD_RELEASE, 16'd0, 16'd16);
        queue_req(CMD_RELEASE, 16'd0, 16'd16);
        queue_req(CMD_RELEASE, 16'd0, 16'd64);
        queue_req(CMD_RELEASE, 16'd0, 16'd64);
        queue_req(CMD_ALLOC, 16'd20, 16'd0);
        queue_req(CMD_RESIZE, 16'd4, 16'd16);
        queue_req(CMD_RESIZE, 16'd500, 16'd16);
        queue_req(CMD_RESIZE, 16'd0, 16'd176);
        queue_req(CMD_RESIZE, 16'd10, 16'd0);
        queue_req(CMD_RESIZE, 16'hFFFF, 16'd16);
        queue_req(CMD_ALLOC, 16'hFFFF, 16'd0);
        queue_req(CMD_RELEASE, 16'd0, 16'hFFFF);
        queue_req(CMD_RESIZE, 16'd5, 16'd17);
        drain();
        write_limit(32);
        queue_req(CMD_ALLOC, 16'd17, 16'd0);
        queue_req(CMD_ALLOC, 16'd16, 16'd0);
        queue_req(CMD_ALLOC, 16'd1, 16'd0);
        drain();

        // random phases across several limits
        lims = '{65536, 2000, 131071, 600};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_limit(lims[ph]);
            for (int n = 0; n < 250; n++)
            begin
                int unsigned p;
                p = $urandom_range(0, 99);
                if (p < 40)
                    queue_req(CMD_ALLOC, pick_size(), UADDR_W'($urandom()));
                else if (p < 75)
                    queue_req(CMD_RELEASE, SIZE_W'($urandom()), pick_addr());
                else if (p < 97)
                    queue_req(CMD_RESIZE, pick_size(), pick_addr());
                else
                    queue_req(CMD_BAD, SIZE_W'($urandom()), UADDR_W'($urandom()));
            end
            drain();
        end
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
